// ===== sv/eci_pkg.sv =====
// ============================================================================
// eci_pkg
// Shared types and constants for the easing curve interpolator.
// ============================================================================
`default_nettype none

package eci_pkg;

  // Fixed field widths
  localparam int DATA_W  = 16;
  localparam int DIFF_W  = 17;
  localparam int VALUE_W = 18;
  localparam int FRAC_W  = 11;

  // Curve select codes
  localparam logic [1:0] CURVE_QUART = 2'd0;
  localparam logic [1:0] CURVE_CUBIC = 2'd1;
  localparam logic [1:0] CURVE_BACK  = 2'd2;

  // Ease-out-back coefficients: q^2 * (362 Q - 618 q) / (256 Q^2)
  localparam int BACK_SLOPE = 618;
  localparam int BACK_BASE  = 362;
  localparam int BACK_SHIFT = 8;

  // Input transaction
  typedef struct packed {
    logic        [1:0]        req_type;
    logic        [DATA_W-1:0] elapsed_time;
    logic        [DATA_W-1:0] total_duration;
    logic signed [DATA_W-1:0] start_level;
    logic signed [DATA_W-1:0] end_level;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic signed [VALUE_W-1:0] eased_value;
    logic        [FRAC_W-1:0]  eased_fraction;
  } out_item_t;

  // Sideband that rides along the pipeline with each transaction
  typedef struct packed {
    logic        [1:0]        sel;
    logic signed [DATA_W-1:0] start;
    logic signed [DIFF_W-1:0] diff;
  } side_t;

endpackage

`default_nettype wire

// ===== sv/eci_div_step.sv =====
// ============================================================================
// eci_div_step
// One registered restoring-division step of the progress divider.
// ============================================================================
`default_nettype none

module eci_div_step #(
  parameter int QW = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // upstream side
  input  wire logic                       up_valid,
  output logic                            up_hold,
  input  wire logic [eci_pkg::DATA_W-1:0] up_rem,
  input  wire logic [eci_pkg::DATA_W-1:0] up_dur,
  input  wire logic [QW-1:0]              up_quo,
  input  wire logic                       up_full,
  input  wire eci_pkg::side_t             up_side,
  // downstream side
  output logic                            dn_valid,
  input  wire logic                       dn_hold,
  output logic [eci_pkg::DATA_W-1:0]      dn_rem,
  output logic [eci_pkg::DATA_W-1:0]      dn_dur,
  output logic [QW-1:0]                   dn_quo,
  output logic                            dn_full,
  output eci_pkg::side_t                  dn_side
);

  logic                         v_r;
  logic [eci_pkg::DATA_W-1:0]   rem_r;
  logic [eci_pkg::DATA_W-1:0]   rem_nxt;
  logic [eci_pkg::DATA_W-1:0]   dur_r;
  logic [QW-1:0]                quo_r;
  logic [QW-1:0]                quo_nxt;
  logic                         full_r;
  eci_pkg::side_t               side_r;
  logic                         load;
  logic [eci_pkg::DATA_W:0]     rem2;
  logic [eci_pkg::DATA_W:0]     rem_sub;
  logic                         ge;

  // Stage advances when empty or when downstream takes its content
  assign up_hold = v_r && dn_hold;
  assign load    = !up_hold;

  // Shift in a zero numerator bit, trial subtract
  assign rem2    = {up_rem, 1'b0};
  assign rem_sub = rem2 - {1'b0, up_dur};
  assign ge      = rem2 >= {1'b0, up_dur};
  assign rem_nxt = ge ? rem_sub[eci_pkg::DATA_W-1:0] : rem2[eci_pkg::DATA_W-1:0];
  assign quo_nxt = {up_quo[QW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      rem_r  <= rem_nxt;
      dur_r  <= up_dur;
      quo_r  <= quo_nxt;
      full_r <= up_full;
      side_r <= up_side;
    end
  end

  assign dn_valid = v_r;
  assign dn_rem   = rem_r;
  assign dn_dur   = dur_r;
  assign dn_quo   = quo_r;
  assign dn_full  = full_r;
  assign dn_side  = side_r;

endmodule

`default_nettype wire

// ===== sv/eci_curve.sv =====
// ============================================================================
// eci_curve
// Three-stage curve evaluator: square, shared multiply, scale and select.
// ============================================================================
`default_nettype none

module eci_curve #(
  parameter int FRAC_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  output logic                      up_hold,
  input  wire logic [FRAC_BITS:0]   up_p,
  input  wire eci_pkg::side_t       up_side,
  output logic                      dn_valid,
  input  wire logic                 dn_hold,
  output logic [FRAC_BITS:0]        dn_e,
  output eci_pkg::side_t            dn_side
);

  localparam int EW  = FRAC_BITS + 1;
  localparam int SQW = 2 * FRAC_BITS + 2;
  localparam int TW  = FRAC_BITS + 11;
  localparam int MW  = (SQW > TW) ? SQW : TW;
  localparam int PW  = SQW + MW;
  localparam int RSH = 2 * FRAC_BITS + eci_pkg::BACK_SHIFT;
  localparam logic [EW-1:0] ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [EW-1:0] HALF_Q = {2'b01, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [TW-1:0] T_BASE =
    TW'(eci_pkg::BACK_BASE * (1 << FRAC_BITS));
  localparam logic signed [PW-1:0] ONE_W   = {{(PW-EW){1'b0}}, ONE_Q};
  localparam logic signed [PW-1:0] RND_W   = {{(PW-RSH){1'b0}}, {RSH{1'b1}}};
  localparam logic signed [PW-1:0] ZERO_W  = '0;

  // Stage A: q = Q - p, squaring of the curve's base term
  logic                   a_v_r;
  eci_pkg::side_t         a_side_r;
  logic [SQW-1:0]         a_sq_r;
  logic [SQW-1:0]         a_sq_nxt;
  logic signed [TW-1:0]   a_t_r;
  logic signed [TW-1:0]   a_t_nxt;
  logic [EW-1:0]          a_s_r;
  logic                   a_lower_r;
  logic [EW-1:0]          q_a;
  logic [EW-1:0]          s_a;
  logic [EW-1:0]          base_a;
  logic                   lower_a;
  logic                   a_hold;

  // Stage B: shared signed multiplier
  logic                   b_v_r;
  eci_pkg::side_t         b_side_r;
  logic                   b_lower_r;
  logic signed [PW-1:0]   b_prod_r;
  logic signed [PW-1:0]   b_prod_nxt;
  logic signed [SQW-1:0]  sq_b;
  logic signed [MW-1:0]   m_b;
  logic                   b_hold;

  // Stage C: scale and fold
  logic                   c_v_r;
  eci_pkg::side_t         c_side_r;
  logic [EW-1:0]          c_e_r;
  logic [EW-1:0]          c_e_nxt;
  logic signed [PW-1:0]   cub_c;
  logic signed [PW-1:0]   e_w;
  logic                   c_hold;

  // Hold chain, from the output back to the input
  assign c_hold  = c_v_r && dn_hold;
  assign b_hold  = b_v_r && c_hold;
  assign a_hold  = a_v_r && b_hold;
  assign up_hold = a_hold;

  // Stage A logic
  assign q_a      = ONE_Q - up_p;
  assign lower_a  = up_p < HALF_Q;
  assign s_a      = lower_a ? up_p : q_a;
  assign base_a   = (up_side.sel == eci_pkg::CURVE_CUBIC) ? s_a : q_a;
  assign a_sq_nxt = SQW'(base_a) * SQW'(base_a);
  assign a_t_nxt  = T_BASE - $signed(TW'(eci_pkg::BACK_SLOPE) * TW'(q_a));

  // Stage B logic: pick the second factor per curve
  assign sq_b = $signed(a_sq_r);
  always_comb begin
    case (a_side_r.sel)
      eci_pkg::CURVE_CUBIC: m_b = MW'($signed({1'b0, a_s_r}));
      eci_pkg::CURVE_BACK:  m_b = MW'(a_t_r);
      eci_pkg::CURVE_QUART: m_b = MW'(sq_b);
      default:              m_b = MW'(sq_b);
    endcase
  end
  assign b_prod_nxt = PW'(sq_b) * PW'(m_b);

  // Stage C logic: divide by the curve's power of two and fold
  assign cub_c = b_prod_r >>> (2 * FRAC_BITS - 2);
  always_comb begin
    case (b_side_r.sel)
      eci_pkg::CURVE_CUBIC: e_w = b_lower_r ? cub_c : (ONE_W - cub_c);
      eci_pkg::CURVE_BACK:
        // truncate toward zero
        e_w = ONE_W + ((b_prod_r + ((b_prod_r < ZERO_W) ? RND_W : ZERO_W)) >>> RSH);
      eci_pkg::CURVE_QUART: e_w = ONE_W - (b_prod_r >>> (3 * FRAC_BITS));
      default:              e_w = ONE_W - (b_prod_r >>> (3 * FRAC_BITS));
    endcase
  end
  assign c_e_nxt = e_w[EW-1:0];

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (!a_hold) a_v_r <= up_valid;
      if (!b_hold) b_v_r <= a_v_r;
      if (!c_hold) c_v_r <= b_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!a_hold && up_valid) begin
      a_side_r  <= up_side;
      a_sq_r    <= a_sq_nxt;
      a_t_r     <= a_t_nxt;
      a_s_r     <= s_a;
      a_lower_r <= lower_a;
    end
    if (!b_hold && a_v_r) begin
      b_side_r  <= a_side_r;
      b_lower_r <= a_lower_r;
      b_prod_r  <= b_prod_nxt;
    end
    if (!c_hold && b_v_r) begin
      c_side_r <= b_side_r;
      c_e_r    <= c_e_nxt;
    end
  end

  assign dn_valid = c_v_r;
  assign dn_e     = c_e_r;
  assign dn_side  = c_side_r;

`ifndef ASSERT_OFF
  // quart and cubic never pass full scale
  a_std_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (c_v_r && (c_side_r.sel != eci_pkg::CURVE_BACK)) |-> (c_e_r <= ONE_Q))
    else $error("eci_curve: non-back curve above full scale");
  // back overshoot stays small
  a_back_bound: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r |-> (c_e_r <= (ONE_Q + (ONE_Q >> 3))))
    else $error("eci_curve: eased fraction out of range");
`endif

endmodule

`default_nettype wire

// ===== sv/eci_mix.sv =====
// ============================================================================
// eci_mix
// Two-stage level interpolation: e * (end - start), then floor shift and add.
// ============================================================================
`default_nettype none

module eci_mix #(
  parameter int FRAC_BITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_hold,
  input  wire logic [FRAC_BITS:0] up_e,
  input  wire eci_pkg::side_t     up_side,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output eci_pkg::out_item_t      out_data
);

  localparam int EW  = FRAC_BITS + 1;
  localparam int P2W = EW + 1 + eci_pkg::DIFF_W;

  // Stage D: product
  logic                              d_v_r;
  logic signed [eci_pkg::DATA_W-1:0] d_start_r;
  logic [EW-1:0]                     d_e_r;
  logic signed [P2W-1:0]             d_prod_r;
  logic signed [P2W-1:0]             d_prod_nxt;
  logic                              d_hold;

  // Stage E: output register
  logic                              o_v_r;
  eci_pkg::out_item_t                o_data_r;
  eci_pkg::out_item_t                o_data_nxt;
  logic signed [P2W-1:0]             sum_e;
  logic [31:0]                       frac_ext;
  logic                              o_hold;

  assign o_hold  = o_v_r && out_stall;
  assign d_hold  = d_v_r && o_hold;
  assign up_hold = d_hold;

  assign d_prod_nxt = P2W'($signed({1'b0, up_e})) * P2W'(up_side.diff);

  // floor division by Q is an arithmetic shift
  assign sum_e    = P2W'(d_start_r) + (d_prod_r >>> FRAC_BITS);
  assign frac_ext = 32'(d_e_r);
  always_comb begin
    o_data_nxt.eased_value    = sum_e[eci_pkg::VALUE_W-1:0];
    o_data_nxt.eased_fraction = frac_ext[eci_pkg::FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (!d_hold) d_v_r <= up_valid;
      if (!o_hold) o_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!d_hold && up_valid) begin
      d_start_r <= up_side.start;
      d_e_r     <= up_e;
      d_prod_r  <= d_prod_nxt;
    end
    if (!o_hold && d_v_r) begin
      o_data_r <= o_data_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_data_r;

endmodule

`default_nettype wire

// ===== sv/easing_curve_interpolator_core.sv =====
// ============================================================================
// easing_curve_interpolator_core
// Pipelined easing curve evaluator and level interpolator.
// ============================================================================
// Takes one transaction per clock while in_stall is low and returns one
// result per transaction, in order. The pipe is made of the progress
// divider, a chain of FRACTION_BITS registered restoring-division steps,
// followed by three curve stages (square, shared multiply, scale) and two
// interpolation stages (multiply, shift and add into the output register).
// Every stage holds its own valid bit; a stall on the output holds only
// the occupied stages, so bubbles are squeezed out and in_stall rises only
// once the whole pipe is full and the output is stalled. Curve select 3
// behaves as ease-out-quart.
`default_nettype none

module easing_curve_interpolator_core #(
  parameter int FRACTION_BITS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire eci_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output eci_pkg::out_item_t     out_data
);

  localparam int F = FRACTION_BITS;
  localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

  // Divider pipeline taps, index k feeds step k
  logic                         dv    [0:F];
  logic                         dh    [0:F];
  logic [eci_pkg::DATA_W-1:0]   drem  [0:F];
  logic [eci_pkg::DATA_W-1:0]   ddur  [0:F];
  logic [F-1:0]                 dquo  [0:F];
  logic                         dfull [0:F];
  eci_pkg::side_t               dside [0:F];

  logic [F:0]                   prog;
  logic                         cv_valid;
  logic                         cv_hold;
  logic [F:0]                   cv_e;
  eci_pkg::side_t               cv_side;
  logic                         dh_mix;

  // Entry: saturate progress, form the level difference
  assign dv[0]         = in_valid;
  assign in_stall      = dh[0];
  assign drem[0]       = in_data.elapsed_time;
  assign ddur[0]       = in_data.total_duration;
  assign dquo[0]       = '0;
  assign dfull[0]      = in_data.elapsed_time >= in_data.total_duration;
  assign dside[0].sel  = in_data.req_type;
  assign dside[0].start = in_data.start_level;
  assign dside[0].diff =
    $signed({in_data.end_level[eci_pkg::DATA_W-1], in_data.end_level}) -
    $signed({in_data.start_level[eci_pkg::DATA_W-1], in_data.start_level});

  // Progress divider: one quotient bit per stage
  for (genvar k = 0; k < F; k++) begin : g_div
    eci_div_step #(.QW(F)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv[k]),
      .up_hold  (dh[k]),
      .up_rem   (drem[k]),
      .up_dur   (ddur[k]),
      .up_quo   (dquo[k]),
      .up_full  (dfull[k]),
      .up_side  (dside[k]),
      .dn_valid (dv[k+1]),
      .dn_hold  (dh[k+1]),
      .dn_rem   (drem[k+1]),
      .dn_dur   (ddur[k+1]),
      .dn_quo   (dquo[k+1]),
      .dn_full  (dfull[k+1]),
      .dn_side  (dside[k+1])
    );
  end

  assign prog  = dfull[F] ? ONE_Q : {1'b0, dquo[F]};
  assign dh[F] = cv_hold;

  // Curve evaluation
  eci_curve #(.FRAC_BITS(F)) u_curve (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dv[F]),
    .up_hold  (cv_hold),
    .up_p     (prog),
    .up_side  (dside[F]),
    .dn_valid (cv_valid),
    .dn_hold  (dh_mix),
    .dn_e     (cv_e),
    .dn_side  (cv_side)
  );

  // Level interpolation and output register
  eci_mix #(.FRAC_BITS(F)) u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (cv_valid),
    .up_hold   (dh_mix),
    .up_e      (cv_e),
    .up_side   (cv_side),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // input is held back only by a stalled, occupied output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("core: input stalled without a stalled output");
  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("core: result presented right after reset");
`endif

endmodule

`default_nettype wire
